FILE: rtl/core/mqtt_packet_stream_parser_unit_assert.svh
// Assertion macros shared by the parser checker.
`ifndef MQTT_PACKET_STREAM_PARSER_UNIT_ASSERT_SVH
`define MQTT_PACKET_STREAM_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define MPSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpsp check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define MPSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpsp check failed");

`endif

FILE: rtl/core/mpsp_pkg.sv
// Shared types, codes and helpers of the MQTT stream parser.
`timescale 1ns / 1ps

package mpsp_pkg;

  localparam int MAX_LENGTH_BYTES = 4;
  localparam int LenW    = 28;
  localparam int LenCntW = 3;

  // byte role codes
  localparam logic [3:0] ROLE_HEADER    = 4'd0;
  localparam logic [3:0] ROLE_LENGTH    = 4'd1;
  localparam logic [3:0] ROLE_ACK_FLAGS = 4'd2;
  localparam logic [3:0] ROLE_ACK_CODE  = 4'd3;
  localparam logic [3:0] ROLE_TOPIC_LEN = 4'd4;
  localparam logic [3:0] ROLE_TOPIC     = 4'd5;
  localparam logic [3:0] ROLE_PKT_ID    = 4'd6;
  localparam logic [3:0] ROLE_PAYLOAD   = 4'd7;
  localparam logic [3:0] ROLE_OTHER     = 4'd8;
  localparam logic [3:0] ROLE_MALFORMED = 4'd9;

  // control packet types
  localparam logic [3:0] TYPE_CONNACK  = 4'd2;
  localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
  localparam logic [3:0] TYPE_PINGRESP = 4'd13;

  typedef struct packed {
    logic [3:0]      byte_role;
    logic [7:0]      byte_value;
    logic [3:0]      packet_type;
    logic            dup_flag;
    logic [1:0]      qos_level;
    logic            retain_flag;
    logic [LenW-1:0] remaining_length;
    logic [15:0]     topic_length;
    logic [15:0]     packet_id;
    logic            packet_end;
    logic            length_error;
  } result_t;

  // 7-bit length group placed at its position, low group first
  function automatic logic [LenW-1:0] len_group(input logic [6:0] bits,
                                                input logic [1:0] idx);
    logic [LenW-1:0] g;
    g = {{(LenW-7){1'b0}}, bits};
    case (idx)
      2'd0:    len_group = g;
      2'd1:    len_group = g << 7;
      2'd2:    len_group = g << 14;
      2'd3:    len_group = g << 21;
      default: len_group = g;
    endcase
  endfunction

endpackage

FILE: rtl/core/mqtt_packet_stream_parser_unit.sv
// Top level of the MQTT stream parser: one role-tagged result word per input byte.
// Accepted bytes pass the input register, then the result register as result words.
// Throughput: one byte per cycle without master stalls; the decode step from input
//   register to result register is the only loop, closed via the parse state registers.
// Reset: async active low; empties both registers and returns to expecting a header.
`timescale 1ns / 1ps

module mqtt_packet_stream_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] byte_value, [11:8] packet_type, [12] dup_flag, [14:13] qos_level,
  // [15] retain_flag, [43:16] remaining_length, [59:44] topic_length,
  // [75:60] packet_id, [76] length_error, [79:77] zero
  output logic [79:0] m_axis_tdata_o,
  output logic [3:0]  m_axis_tuser_o,   // [3:0] byte_role
  output logic        m_axis_tlast_o    // packet_end
);
  import mpsp_pkg::*;

  logic       in_valid;
  logic [7:0] in_data;
  logic       out_free;
  logic       advance;
  result_t    step_result;
  result_t    out_result;

  // a held input word steps the parser when the result slot can take it
  assign advance = in_valid && out_free;

  mpsp_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_data_i  (s_axis_tdata_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .data_o    (in_data)
  );

  // parse state only moves when a word advances
  mpsp_decoder u_dec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .data_i   (in_data),
    .result_o (step_result)
  );

  mpsp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .result_i   (step_result),
    .free_o     (out_free),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_result_o (out_result)
  );

  // pack the result word, highest field first
  assign m_axis_tdata_o = {3'b000,
                           out_result.length_error,
                           out_result.packet_id,
                           out_result.topic_length,
                           out_result.remaining_length,
                           out_result.retain_flag,
                           out_result.qos_level,
                           out_result.dup_flag,
                           out_result.packet_type,
                           out_result.byte_value};
  assign m_axis_tuser_o = out_result.byte_role;
  assign m_axis_tlast_o = out_result.packet_end;

endmodule

FILE: rtl/core/mpsp_in_stage.sv
// Input word register of the MQTT stream parser.
`timescale 1ns / 1ps

module mpsp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_data_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] data_o
);
  import mpsp_pkg::*;

  logic       valid_q;
  logic [7:0] data_q;

  // free slot, or the held word moves on this cycle
  assign s_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      data_q <= s_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/mpsp_decoder.sv
// Parse state and per-word role decode of the MQTT stream parser.
`timescale 1ns / 1ps

module mpsp_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        data_i,
  output mpsp_pkg::result_t result_o
);
  import mpsp_pkg::*;

  typedef enum logic [3:0] {
    PH_HDR     = 4'd0,
    PH_LEN     = 4'd1,
    PH_ACKF    = 4'd2,
    PH_ACKC    = 4'd3,
    PH_TLEN_HI = 4'd4,
    PH_TLEN_LO = 4'd5,
    PH_TOPIC   = 4'd6,
    PH_ID_HI   = 4'd7,
    PH_ID_LO   = 4'd8,
    PH_PAYLOAD = 4'd9,
    PH_OTHER   = 4'd10
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [7:0]         hdr_q, hdr_d;
  logic [LenW-1:0]    acc_q, acc_d;
  logic [LenCntW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0]    left_q, left_d;
  logic [15:0]        tlen_q, tlen_d;
  logic [15:0]        tleft_q, tleft_d;
  logic [15:0]        pid_q, pid_d;

  logic [3:0] role;
  logic       pkt_end;
  logic       len_err;
  logic       in_body;
  logic [3:0] ptype;
  phase_e     after_topic;
  phase_e     first_body;

  assign ptype       = hdr_q[7:4];
  assign after_topic = (hdr_q[2:1] != 2'd0) ? PH_ID_HI : PH_PAYLOAD;

  always_comb begin
    case (ptype)
      TYPE_CONNACK:  first_body = PH_ACKF;
      TYPE_PUBLISH:  first_body = PH_TLEN_HI;
      TYPE_PINGRESP: first_body = PH_ID_HI;
      default:       first_body = PH_OTHER;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    tlen_d  = tlen_q;
    tleft_d = tleft_q;
    pid_d   = pid_q;
    role    = ROLE_OTHER;
    pkt_end = 1'b0;
    len_err = 1'b0;
    in_body = 1'b1;

    case (phase_q)
      PH_LEN: begin
        in_body = 1'b0;
        role    = ROLE_LENGTH;
        acc_d   = acc_q + len_group(data_i[6:0], cnt_q[1:0]);
        cnt_d   = cnt_q + LenCntW'(1);
        if (data_i[7]) begin
          if (cnt_d >= LenCntW'(MAX_LENGTH_BYTES)) begin
            role    = ROLE_MALFORMED;
            len_err = 1'b1;
            pkt_end = 1'b1;
            phase_d = PH_HDR;
          end
        end else begin
          left_d = acc_d;
          if (acc_d == '0) begin
            pkt_end = 1'b1;
            phase_d = PH_HDR;
          end else begin
            phase_d = first_body;
          end
        end
      end
      PH_ACKF: begin
        role    = ROLE_ACK_FLAGS;
        phase_d = PH_ACKC;
      end
      PH_ACKC: begin
        role    = ROLE_ACK_CODE;
        phase_d = PH_OTHER;
      end
      PH_TLEN_HI: begin
        role    = ROLE_TOPIC_LEN;
        tlen_d  = {data_i, 8'd0};
        phase_d = PH_TLEN_LO;
      end
      PH_TLEN_LO: begin
        role   = ROLE_TOPIC_LEN;
        tlen_d = tlen_q | {8'd0, data_i};
        // topic must fit in the body left after this byte
        if ((left_q != '0) && ({{(LenW-16){1'b0}}, tlen_d} > (left_q - LenW'(1)))) begin
          role    = ROLE_MALFORMED;
          len_err = 1'b1;
          phase_d = PH_OTHER;
        end else begin
          tleft_d = tlen_d;
          phase_d = (tlen_d != 16'd0) ? PH_TOPIC : after_topic;
        end
      end
      PH_TOPIC: begin
        role    = ROLE_TOPIC;
        tleft_d = tleft_q - 16'd1;
        if (tleft_d == 16'd0) begin
          phase_d = after_topic;
        end
      end
      PH_ID_HI: begin
        role    = ROLE_PKT_ID;
        pid_d   = {data_i, 8'd0};
        phase_d = PH_ID_LO;
      end
      PH_ID_LO: begin
        role    = ROLE_PKT_ID;
        pid_d   = pid_q | {8'd0, data_i};
        phase_d = (ptype == TYPE_PUBLISH) ? PH_PAYLOAD : PH_OTHER;
      end
      PH_PAYLOAD: begin
        role = ROLE_PAYLOAD;
      end
      PH_OTHER: begin
        role = ROLE_OTHER;
      end
      default: begin
        // header byte; unused phase codes land here too
        in_body = 1'b0;
        role    = ROLE_HEADER;
        hdr_d   = data_i;
        acc_d   = '0;
        cnt_d   = '0;
        left_d  = '0;
        tlen_d  = '0;
        tleft_d = '0;
        pid_d   = '0;
        phase_d = PH_LEN;
      end
    endcase

    // body length governs where the packet ends
    if (in_body) begin
      if (left_d != '0) begin
        left_d = left_d - LenW'(1);
      end
      if (left_d == '0) begin
        pkt_end = 1'b1;
        phase_d = PH_HDR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      hdr_q   <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      tlen_q  <= '0;
      tleft_q <= '0;
      pid_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      tlen_q  <= tlen_d;
      tleft_q <= tleft_d;
      pid_q   <= pid_d;
    end
  end

  always_comb begin
    result_o.byte_role        = role;
    result_o.byte_value       = data_i;
    result_o.packet_type      = hdr_d[7:4];
    result_o.dup_flag         = hdr_d[3];
    result_o.qos_level        = hdr_d[2:1];
    result_o.retain_flag      = hdr_d[0];
    result_o.remaining_length = acc_d;
    result_o.topic_length     = tlen_d;
    result_o.packet_id        = pid_d;
    result_o.packet_end       = pkt_end;
    result_o.length_error     = len_err;
  end

endmodule

FILE: rtl/core/mpsp_out_stage.sv
// Result word register of the MQTT stream parser.
`timescale 1ns / 1ps

module mpsp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mpsp_pkg::result_t result_i,
  output logic              free_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output mpsp_pkg::result_t m_result_o
);
  import mpsp_pkg::*;

  logic    valid_q;
  result_t result_q;

  // slot can take a new word when empty or drained this cycle
  assign free_o = !valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign m_valid_o  = valid_q;
  assign m_result_o = result_q;

endmodule

FILE: rtl/core/mpsp_checker.sv
// Port-level checks of the MQTT stream parser, bound to the top level.
`timescale 1ns / 1ps
`include "mqtt_packet_stream_parser_unit_assert.svh"

module mpsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o,
  input logic [3:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import mpsp_pkg::*;

  // stalled result word holds
  `MPSP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))

  // error flag goes with the malformed role and nothing else
  `MPSP_ASSERT_NOW(a_err_role, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[76] == (m_axis_tuser_o == ROLE_MALFORMED))

  // a header word clears the length, topic length and id values and does not end the packet
  `MPSP_ASSERT_NOW(a_hdr_clear, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o == ROLE_HEADER), (m_axis_tdata_o[75:16] == 60'd0) && !m_axis_tlast_o)

  // a bad length encoding closes the packet, checked for all but PUBLISH words
  `MPSP_ASSERT_NOW(a_len_err_end, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[76] && (m_axis_tdata_o[75:44] == 32'd0) && (m_axis_tdata_o[15:0] != 16'd0) && m_axis_tdata_o[7], m_axis_tlast_o || (m_axis_tdata_o[11:8] == TYPE_PUBLISH))

endmodule

bind mqtt_packet_stream_parser_unit mpsp_checker u_mpsp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the MQTT stream parser: directed table, then random packet traffic.
`timescale 1ns / 1ps

module tb_top;
  import mpsp_pkg::*;

  // parse phases of the local decoder
  typedef enum logic [3:0] {
    P_HDR, P_LEN, P_ACKF, P_ACKC, P_TLEN_HI, P_TLEN_LO,
    P_TOPIC, P_ID_HI, P_ID_LO, P_PAYLOAD, P_OTHER
  } parse_phase_e;

  // one directed stream byte; role/last/err replace the decoded expectation only when pinned is set
  typedef struct packed {
    logic [7:0] data;
    logic       pinned;
    logic [3:0] role;
    logic       last;
    logic       err;
  } stim_row_t;

  localparam int RANDOM_WORDS = 1700;
  localparam int TAIL_CYCLES  = 8;

  localparam stim_row_t DIRECTED_ROWS [27] = '{
    // out of reset: PUBLISH header with zero remaining length
    '{8'h30, 1'b1, ROLE_HEADER,    1'b0, 1'b0},
    '{8'h00, 1'b1, ROLE_LENGTH,    1'b1, 1'b0},
    // all-ones header, length keeps its continuation bit through four bytes
    '{8'hFF, 1'b1, ROLE_HEADER,    1'b0, 1'b0},
    '{8'hFF, 1'b1, ROLE_LENGTH,    1'b0, 1'b0},
    '{8'hFF, 1'b1, ROLE_LENGTH,    1'b0, 1'b0},
    '{8'hFF, 1'b1, ROLE_LENGTH,    1'b0, 1'b0},
    '{8'hFF, 1'b1, ROLE_MALFORMED, 1'b1, 1'b1},
    // CONNACK: ack flags, return code
    '{8'h20, 1'b0, '0, 1'b0, 1'b0},
    '{8'h02, 1'b0, '0, 1'b0, 1'b0},
    '{8'h01, 1'b0, '0, 1'b0, 1'b0},
    '{8'h00, 1'b0, '0, 1'b0, 1'b0},
    // PUBLISH QoS 3, topic length 5 with only two body bytes
    '{8'h36, 1'b0, '0, 1'b0, 1'b0},
    '{8'h02, 1'b0, '0, 1'b0, 1'b0},
    '{8'h00, 1'b0, '0, 1'b0, 1'b0},
    '{8'h05, 1'b1, ROLE_MALFORMED, 1'b1, 1'b1},
    // PINGRESP carrying an id
    '{8'hD0, 1'b0, '0, 1'b0, 1'b0},
    '{8'h02, 1'b0, '0, 1'b0, 1'b0},
    '{8'h12, 1'b0, '0, 1'b0, 1'b0},
    '{8'h34, 1'b0, '0, 1'b0, 1'b0},
    // PUBLISH QoS 1: one topic byte, id, one payload byte
    '{8'h32, 1'b0, '0, 1'b0, 1'b0},
    '{8'h06, 1'b0, '0, 1'b0, 1'b0},
    '{8'h00, 1'b0, '0, 1'b0, 1'b0},
    '{8'h01, 1'b0, '0, 1'b0, 1'b0},
    '{8'h61, 1'b0, '0, 1'b0, 1'b0},
    '{8'hAB, 1'b0, '0, 1'b0, 1'b0},
    '{8'hCD, 1'b0, '0, 1'b0, 1'b0},
    '{8'h80, 1'b0, '0, 1'b0, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        s_tvalid     = 1'b0;
  logic [7:0]  s_tdata      = 8'h00;
  logic        m_tready     = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [79:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  // pinned expectation travelling with the byte on the slave side
  logic        pin_en   = 1'b0;
  logic [3:0]  pin_role = '0;
  logic        pin_last = 1'b0;
  logic        pin_err  = 1'b0;

  // traffic shaping: steady modes switch idling off for a stretch
  logic src_steady  = 1'b0;
  logic sink_steady = 1'b0;
  int unsigned sink_hold = 0;

  // decoder state, reset values
  parse_phase_e phase     = P_HDR;
  logic [7:0]   cur_hdr   = '0;
  logic [27:0]  len_acc   = '0;
  logic [2:0]   len_cnt   = '0;
  logic [27:0]  body_left = '0;
  logic [15:0]  tlen      = '0;
  logic [15:0]  topic_left = '0;
  logic [15:0]  pkt_id    = '0;

  result_t     parsed_q [$];   // decoded words waiting for the DUT's result
  logic [7:0]  pkt_bytes [$];  // packet under construction
  int unsigned mismatch_count = 0;
  int unsigned words_checked  = 0;
  int unsigned packet_ends    = 0;
  int unsigned malformed_seen = 0;
  int unsigned random_words   = 0;
  int unsigned random_packets = 0;

  mqtt_packet_stream_parser_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop, several times the slowest legal run
  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // idle length: mostly none, often short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Decode one stream byte: advances the local state, returns the word the DUT must give.
  function automatic result_t decode_byte(input logic [7:0] b);
    result_t      r;
    logic [3:0]   role;
    logic         last;
    logic         err;
    logic         in_body;
    logic [31:0]  room;
    parse_phase_e nxt;
    parse_phase_e after_topic;
    role        = ROLE_OTHER;
    last        = 1'b0;
    err         = 1'b0;
    in_body     = 1'b1;
    nxt         = phase;
    // id only when QoS is nonzero, QoS 3 included
    after_topic = (cur_hdr[2:1] != 2'd0) ? P_ID_HI : P_PAYLOAD;
    case (phase)
      P_LEN: begin
        in_body = 1'b0;
        role    = ROLE_LENGTH;
        len_acc = len_acc + ({21'd0, b[6:0]} << (7 * len_cnt[1:0]));
        len_cnt = len_cnt + 3'd1;
        if (b[7]) begin
          // continuation on the last allowed length byte
          if (len_cnt >= MAX_LENGTH_BYTES) begin
            role = ROLE_MALFORMED;
            err  = 1'b1;
            last = 1'b1;
            nxt  = P_HDR;
          end
        end else begin
          body_left = len_acc;
          if (len_acc == 28'd0) begin
            last = 1'b1;
            nxt  = P_HDR;
          end else if (cur_hdr[7:4] == TYPE_CONNACK) begin
            nxt = P_ACKF;
          end else if (cur_hdr[7:4] == TYPE_PUBLISH) begin
            nxt = P_TLEN_HI;
          end else if (cur_hdr[7:4] == TYPE_PINGRESP) begin
            nxt = P_ID_HI;
          end else begin
            nxt = P_OTHER;
          end
        end
      end
      P_ACKF: begin
        role = ROLE_ACK_FLAGS;
        nxt  = P_ACKC;
      end
      P_ACKC: begin
        role = ROLE_ACK_CODE;
        nxt  = P_OTHER;
      end
      P_TLEN_HI: begin
        role = ROLE_TOPIC_LEN;
        tlen = {b, 8'h00};
        nxt  = P_TLEN_LO;
      end
      P_TLEN_LO: begin
        role = ROLE_TOPIC_LEN;
        tlen = tlen | {8'h00, b};
        room = {4'h0, body_left} - 32'd1;
        if ({16'h0000, tlen} > room) begin
          // topic cannot fit in what is left of the body
          role = ROLE_MALFORMED;
          err  = 1'b1;
          nxt  = P_OTHER;
        end else begin
          topic_left = tlen;
          nxt = (tlen != 16'd0) ? P_TOPIC : after_topic;
        end
      end
      P_TOPIC: begin
        role       = ROLE_TOPIC;
        topic_left = topic_left - 16'd1;
        if (topic_left == 16'd0) nxt = after_topic;
      end
      P_ID_HI: begin
        role   = ROLE_PKT_ID;
        pkt_id = {b, 8'h00};
        nxt    = P_ID_LO;
      end
      P_ID_LO: begin
        role   = ROLE_PKT_ID;
        pkt_id = pkt_id | {8'h00, b};
        nxt    = (cur_hdr[7:4] == TYPE_PUBLISH) ? P_PAYLOAD : P_OTHER;
      end
      P_PAYLOAD: role = ROLE_PAYLOAD;
      P_OTHER:   role = ROLE_OTHER;
      default: begin
        // header byte: new packet, everything else cleared
        in_body    = 1'b0;
        role       = ROLE_HEADER;
        cur_hdr    = b;
        len_acc    = '0;
        len_cnt    = '0;
        body_left  = '0;
        tlen       = '0;
        topic_left = '0;
        pkt_id     = '0;
        nxt        = P_LEN;
      end
    endcase
    // in the body, the body length decides where the packet ends
    if (in_body) begin
      if (body_left != 28'd0) body_left = body_left - 28'd1;
      if (body_left == 28'd0) begin
        last = 1'b1;
        nxt  = P_HDR;
      end
    end
    phase = nxt;

    r.byte_role        = role;
    r.byte_value       = b;
    r.packet_type      = cur_hdr[7:4];
    r.dup_flag         = cur_hdr[3];
    r.qos_level        = cur_hdr[2:1];
    r.retain_flag      = cur_hdr[0];
    r.remaining_length = len_acc;
    r.topic_length     = tlen;
    r.packet_id        = pkt_id;
    r.packet_end       = last;
    r.length_error     = err;
    return r;
  endfunction

  task automatic cmp(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("word %0d: %s expected 0x%0h, got 0x%0h", words_checked, name, want, got);
    end
  endtask

  // Both handshakes are sampled here, input first, so a word's decode is queued
  // before any result in the same edge is matched.
  always @(posedge clk_i) begin : scoreboard
    result_t fresh;
    result_t want;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        fresh = decode_byte(s_tdata);
        if (pin_en) begin
          fresh.byte_role    = pin_role;
          fresh.packet_end   = pin_last;
          fresh.length_error = pin_err;
        end
        parsed_q.push_back(fresh);
      end
      if (m_tvalid && m_tready) begin
        if (parsed_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("word %0d: result arrived with no byte outstanding", words_checked);
        end else begin
          want = parsed_q.pop_front();
          cmp("byte_role",        32'(want.byte_role),        32'(m_tuser));
          cmp("byte_value",       32'(want.byte_value),       32'(m_tdata[7:0]));
          cmp("packet_type",      32'(want.packet_type),      32'(m_tdata[11:8]));
          cmp("dup_flag",         32'(want.dup_flag),         32'(m_tdata[12]));
          cmp("qos_level",        32'(want.qos_level),        32'(m_tdata[14:13]));
          cmp("retain_flag",      32'(want.retain_flag),      32'(m_tdata[15]));
          cmp("remaining_length", 32'(want.remaining_length), 32'(m_tdata[43:16]));
          cmp("topic_length",     32'(want.topic_length),     32'(m_tdata[59:44]));
          cmp("packet_id",        32'(want.packet_id),        32'(m_tdata[75:60]));
          cmp("length_error",     32'(want.length_error),     32'(m_tdata[76]));
          cmp("pad_bits",         32'd0,                      32'(m_tdata[79:77]));
          cmp("packet_end",       32'(want.packet_end),       32'(m_tlast));
          if (want.packet_end)   packet_ends++;
          if (want.length_error) malformed_seen++;
        end
        words_checked++;
      end
    end
  end

  // master side back-pressure
  always @(negedge clk_i) begin
    if (sink_hold != 0) begin
      m_tready  <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      m_tready <= 1'b1;
      if (!sink_steady) sink_hold <= idle_len();
    end
  end

  // One byte on the slave side: optional idle gap, then hold until accepted.
  task automatic send_word(input logic [7:0] b, input logic pin, input logic [3:0] role,
                           input logic last, input logic err);
    int unsigned gap;
    gap = src_steady ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    pin_en   <= pin;
    pin_role <= role;
    pin_last <= last;
    pin_err  <= err;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic wait_until_drained();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk_i);
  endtask

  // 7-bit groups, low first; sometimes padded with zero groups up to four bytes
  task automatic add_length(input int unsigned v);
    int unsigned need;
    int unsigned n;
    logic [31:0] grp;
    need = (v < 128) ? 1 : (v < 16384) ? 2 : 3;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(need, MAX_LENGTH_BYTES) : need;
    for (int i = 0; i < n; i++) begin
      grp = (v >> (7 * i)) & 32'h7F;
      pkt_bytes.push_back({(i < n - 1), grp[6:0]});
    end
  endtask

  // Builds one packet into pkt_bytes: mostly well formed, some broken, some noise.
  task automatic build_packet();
    logic [7:0]  body [$];
    logic [7:0]  head;
    logic [15:0] tl;
    int unsigned kind;
    int unsigned blen;
    int unsigned n;
    int unsigned t4;
    pkt_bytes.delete();
    kind = $urandom_range(0, 99);
    head = 8'($urandom_range(0, 255));
    if (kind < 5) begin
      // noise: any header, short body of random bytes
      blen = $urandom_range(0, 12);
      repeat (blen) body.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 10) begin
      // length field that never terminates
      pkt_bytes.push_back(head);
      repeat (MAX_LENGTH_BYTES) pkt_bytes.push_back({1'b1, 7'($urandom_range(0, 127))});
      return;
    end else if (kind < 16) begin
      // PUBLISH whose topic length overruns the body
      head[7:4] = TYPE_PUBLISH;
      blen = $urandom_range(2, 10);
      tl = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(blen - 1, 300));
      body.push_back(tl[15:8]);
      body.push_back(tl[7:0]);
      repeat (blen - 2) body.push_back(8'($urandom_range(0, 255)));
    end else begin
      t4 = $urandom_range(0, 99);
      if (t4 < 15) begin
        head[7:4] = TYPE_CONNACK;
        repeat (2) body.push_back(8'($urandom_range(0, 255)));
      end else if (t4 < 60) begin
        head[7:4] = TYPE_PUBLISH;
        tl = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
        body.push_back(tl[15:8]);
        body.push_back(tl[7:0]);
        repeat (tl) body.push_back(8'($urandom_range(0, 255)));
        if (head[2:1] != 2'd0) repeat (2) body.push_back(8'($urandom_range(0, 255)));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 10);
        repeat (n) body.push_back(8'($urandom_range(0, 255)));
      end else if (t4 < 75) begin
        head[7:4] = TYPE_PINGRESP;
        if ($urandom_range(0, 1) == 1) repeat (2) body.push_back(8'($urandom_range(0, 255)));
      end else begin
        do t4 = $urandom_range(0, 15);
        while (4'(t4) == TYPE_CONNACK || 4'(t4) == TYPE_PUBLISH || 4'(t4) == TYPE_PINGRESP);
        head[7:4] = 4'(t4);
        repeat ($urandom_range(0, 6)) body.push_back(8'($urandom_range(0, 255)));
      end
      // cut short, or pad beyond the known layout
      n = $urandom_range(0, 9);
      if (n == 0 && body.size() > 1) begin
        blen = $urandom_range(1, body.size() - 1);
        while (body.size() > blen) void'(body.pop_back());
      end else if (n == 1) begin
        repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(0, 255)));
      end
    end
    pkt_bytes.push_back(head);
    add_length(body.size());
    foreach (body[i]) pkt_bytes.push_back(body[i]);
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED_ROWS[i])
      send_word(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].role,
                DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].err);
    // sender holds off until every directed result is back
    wait_until_drained();

    while (random_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 3) src_steady  = !src_steady;
      if ($urandom_range(0, 99) < 3) sink_steady = !sink_steady;
      if ($urandom_range(0, 99) == 0) wait_until_drained();
      build_packet();
      foreach (pkt_bytes[i]) send_word(pkt_bytes[i], 1'b0, '0, 1'b0, 1'b0);
      random_words   += pkt_bytes.size();
      random_packets++;
    end

    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d result words: %0d directed bytes, %0d random bytes in %0d packets.",
             words_checked, $size(DIRECTED_ROWS), random_words, random_packets);
    $display("Packet ends seen: %0d, malformed flags: %0d, field mismatches: %0d.",
             packet_ends, malformed_seen, mismatch_count);
    if (mismatch_count == 0 && parsed_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
